/* hdl/first_fit_region_allocator_assert.svh */
// assertion macros for the region allocator
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFRA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffra assertion failed");

// next-cycle implication
`define FFRA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffra assertion failed");

`endif

/* hdl/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg
// types, constants and helpers shared by the region allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

    localparam int MAX_REGIONS    = 64;
    localparam int POOL_ADDR_BITS = 20;
    localparam int IDX_W   = $clog2(MAX_REGIONS);
    localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
    localparam int OFS_W   = POOL_ADDR_BITS + 1;
    localparam int SIZE_W  = 21;
    localparam int ADDR_W  = 32;
    localparam int ALIGN_W = 4;
    // base + offset + size + alignment mask never carries past this
    localparam int HEAD_W  = ADDR_W + 3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic REG_POOL_BASE  = 1'b0;
    localparam logic REG_POOL_BYTES = 1'b1;

    localparam logic [SIZE_W-1:0] POOL_BYTES_RESET = SIZE_W'(65536);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_GAP   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_MATCH = 2'd3
    } res_status_t;

    typedef struct packed {
        logic                mode;
        logic [SIZE_W-1:0]   size;
        logic [ALIGN_W-1:0]  align_log2;
        logic [ADDR_W-1:0]   address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   address_res;
        logic [1:0]          status;
        logic [SIZE_W-1:0]   bytes_in_use;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic        scan_rd;
        logic        scan_next;
        logic        set_pos;
        logic        sh_rd;
        logic        sh_wr;
        logic        commit;
        logic        load_out;
        res_status_t res;
    } cmd_t;

    typedef struct packed {
        logic             mode;
        logic             full;
        logic             at_end;
        logic             fit_end;
        logic             fit;
        logic             match;
        logic             sh_done;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } stat_t;

    function automatic logic [HEAD_W-1:0] align_mask(input logic [ALIGN_W-1:0] al);
        return (HEAD_W'(1) << al) - HEAD_W'(1);
    endfunction

endpackage

`default_nettype wire

/* hdl/first_fit_region_allocator.sv */
// one transaction at a time: a scan of the table entries, then on a hit a shift of the
// entries that move and a commit; the region table is read once per scan step and
// once per shift step
// reset: asynchronous active low; clears table count, bytes in use, control state
// and the registers to pool_base 0, pool_bytes 65536; no clearing pass on the table
`default_nettype none

module first_fit_region_allocator
    import ffra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

`include "first_fit_region_allocator_assert.svh"

    cmd_t  cmd;
    stat_t st;
    logic  idle;

    ffra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .st       (st),
        .cmd      (cmd),
        .idle     (idle)
    );

    ffra_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign in_stall = !idle;

    `FFRA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `FFRA_ASSERT_IMP(a_fail_addr_zero, out_valid && out_data.status != ST_OK,
                     out_data.address_res == '0)
    `FFRA_ASSERT_IMP(a_count_bound, 1'b1, st.count <= CNT_W'(MAX_REGIONS))

endmodule

`default_nettype wire

/* hdl/ffra_ctrl.sv */
// ----------------------------------------------------------------------------
// ffra_ctrl
// sequencer for scan, table shift and commit of one request
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl
    import ffra_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire stat_t st,
    output cmd_t       cmd,
    output logic       idle
);

    state_t      state_reg, state_next;
    res_status_t res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res    = res_reg;
        idle       = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (st.mode == MODE_ALLOC && st.full)
                begin
                    res_next   = ST_FULL;
                    state_next = S_DONE;
                end
                else if (st.at_end)
                begin
                    if (st.mode == MODE_ALLOC && st.fit_end)
                    begin
                        cmd.set_pos = 1'b1;
                        state_next  = S_SHIFT_RD;
                    end
                    else
                    begin
                        res_next   = (st.mode == MODE_ALLOC) ? ST_NO_GAP : ST_NO_MATCH;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if ((st.mode == MODE_ALLOC && st.fit) || (st.mode == MODE_FREE && st.match))
                begin
                    cmd.set_pos = 1'b1;
                    state_next  = S_SHIFT_RD;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (st.sh_done)
                    state_next = S_COMMIT;
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                res_next   = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/ffra_dp.sv */
// ----------------------------------------------------------------------------
// ffra_dp
// region table, gap walk arithmetic, counters and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_dp
    import ffra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output stat_t            st,
    input  wire in_item_t    in_data,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data
);

    logic [OFS_W-1:0] ofs_mem [MAX_REGIONS];
    logic [OFS_W-1:0] sz_mem  [MAX_REGIONS];

    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] bytes_reg;
    in_item_t          req_reg;
    logic [CNT_W-1:0]  idx_reg, pos_reg, k_reg, count_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [SIZE_W-1:0] used_reg;
    logic [OFS_W-1:0]  rd_ofs_reg, rd_sz_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [HEAD_W-1:0] mask, pool_end, start, lim, need, head_after;
    logic [CNT_W-1:0]  rd_addr;
    logic              mem_we;
    logic [CNT_W-1:0]  wr_addr;
    logic [OFS_W-1:0]  wr_ofs, wr_sz;
    logic [ADDR_W-1:0] want;

    always_comb
    begin
        mask       = align_mask(req_reg.align_log2);
        pool_end   = HEAD_W'(base_reg) + HEAD_W'(bytes_reg);
        start      = HEAD_W'(base_reg) + HEAD_W'(rd_ofs_reg);
        lim        = (start < pool_end) ? start : pool_end;
        need       = head_reg + HEAD_W'(req_reg.size);
        head_after = (start + HEAD_W'(rd_sz_reg) + mask) & ~mask;
        want       = req_reg.address - base_reg;

        st.mode     = req_reg.mode;
        st.full     = (count_reg == CNT_W'(MAX_REGIONS));
        st.at_end   = (idx_reg == count_reg);
        st.fit_end  = (need <= pool_end);
        st.fit      = (need <= lim);
        st.match    = (want == ADDR_W'(rd_ofs_reg)) && (SIZE_W'(rd_sz_reg) == req_reg.size);
        st.sh_done  = (req_reg.mode == MODE_ALLOC) ? (k_reg == pos_reg)
                                                   : (CNT_W'(k_reg + 1'b1) == count_reg);
        st.out_free = !out_valid_reg || !out_stall;
        st.count    = count_reg;

        // the insert direction reads below the write slot, the delete direction above
        if (cmd.sh_rd)
            rd_addr = (req_reg.mode == MODE_FREE) ? CNT_W'(k_reg + 1'b1) : CNT_W'(k_reg - 1'b1);
        else
            rd_addr = idx_reg;

        mem_we  = cmd.sh_wr || (cmd.commit && req_reg.mode == MODE_ALLOC);
        wr_addr = cmd.sh_wr ? k_reg : pos_reg;
        wr_ofs  = cmd.sh_wr ? rd_ofs_reg : OFS_W'(head_reg - HEAD_W'(base_reg));
        wr_sz   = cmd.sh_wr ? rd_sz_reg : OFS_W'(req_reg.size);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ofs_mem[wr_addr[IDX_W-1:0]] <= wr_ofs;
            sz_mem[wr_addr[IDX_W-1:0]]  <= wr_sz;
        end
        if (cmd.scan_rd || cmd.sh_rd)
        begin
            rd_ofs_reg <= ofs_mem[rd_addr[IDX_W-1:0]];
            rd_sz_reg  <= sz_mem[rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg  <= in_data;
            idx_reg  <= '0;
            head_reg <= (HEAD_W'(base_reg) + align_mask(in_data.align_log2))
                        & ~align_mask(in_data.align_log2);
        end
        if (cmd.scan_next)
        begin
            idx_reg  <= CNT_W'(idx_reg + 1'b1);
            head_reg <= head_after;
        end
        if (cmd.set_pos)
        begin
            pos_reg <= idx_reg;
            k_reg   <= (req_reg.mode == MODE_ALLOC) ? count_reg : idx_reg;
        end
        if (cmd.sh_wr)
            k_reg <= (req_reg.mode == MODE_FREE) ? CNT_W'(k_reg + 1'b1) : CNT_W'(k_reg - 1'b1);
        if (cmd.load_out)
        begin
            out_reg.address_res  <= (cmd.res == ST_OK && req_reg.mode == MODE_ALLOC)
                                    ? head_reg[ADDR_W-1:0] : '0;
            out_reg.status       <= cmd.res;
            out_reg.bytes_in_use <= used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            bytes_reg     <= POOL_BYTES_RESET;
            count_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POOL_BASE:  base_reg  <= cfg_data;
                    REG_POOL_BYTES: bytes_reg <= cfg_data[SIZE_W-1:0];
                    default:        base_reg  <= base_reg;
                endcase
            end
            if (cmd.commit)
            begin
                if (req_reg.mode == MODE_ALLOC)
                begin
                    count_reg <= CNT_W'(count_reg + 1'b1);
                    used_reg  <= SIZE_W'(used_reg + req_reg.size);
                end
                else
                begin
                    count_reg <= CNT_W'(count_reg - 1'b1);
                    used_reg  <= SIZE_W'(used_reg - req_reg.size);
                end
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
